// ===== rtl/core/dpm_pkg.sv =====
// Shared types, constants and helpers for the differential drive mixer.
package dpm_pkg;

    localparam int SET_W   = 8;             // stored setting width
    localparam int MAG_W   = 7;             // magnitude of a saturated setting
    localparam int GAIN_W  = 16;            // Q0.16 gain
    localparam int NUM_W   = MAG_W + GAIN_W; // numerator of the scaled divides
    localparam int MUL_W   = 24;            // shared multiplier operand width
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DRV_W   = 20;            // signed drive word, Q2.16 plus headroom
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam int CMP_W   = 8;

    localparam int MAX_TRAVERSAL_SETTING_DEF  = 10;
    localparam int MAX_TURN_SETTING_LEVEL_DEF = 10;

    localparam logic [GAIN_W-1:0] TRAV_GAIN_RST = 16'd55706;
    localparam logic [GAIN_W-1:0] TURN_GAIN_RST = 16'd45875;

    localparam logic [15:0] Q_DRIVE_FULL     = 16'd62259;
    localparam logic [15:0] Q_TURN_FLOOR     = 16'd18678;
    localparam logic [15:0] Q_TURN_FLOOR_RUN = 16'd9372;

    localparam logic CMD_TRAVERSAL = 1'b0;
    localparam logic CMD_TURN      = 1'b1;

    localparam logic REG_TRAV_GAIN = 1'b0;
    localparam logic REG_TURN_GAIN = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TSCALE,
        ST_TRAV_X,
        ST_TRAV_Q,
        ST_TMAX,
        ST_TURN_X,
        ST_TURN_Q,
        ST_MIX,
        ST_SHIFT,
        ST_OUT
    } step_t;

    typedef struct packed {
        step_t step;
        logic  in_ready;
        logic  load_in;
        logic  load_out;
    } ctl_t;

    function automatic logic signed [SET_W-1:0] sat_set(
        input logic signed [SET_W-1:0] v,
        input logic [MAG_W-1:0]        lim
    );
        logic signed [SET_W-1:0] hi;
        logic signed [SET_W-1:0] lo;
        hi = $signed({1'b0, lim});
        lo = -hi;
        if (v > hi)
        begin
            return hi;
        end
        else if (v < lo)
        begin
            return lo;
        end
        return v;
    endfunction

    function automatic logic [MAG_W-1:0] mag_set(input logic signed [SET_W-1:0] v);
        logic signed [SET_W-1:0] n;
        n = -v;
        return v[SET_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
    endfunction

endpackage

// ===== rtl/core/dpm_if.sv =====
// Valid/ready channel interfaces for command and result beats.
interface dpm_in_if import dpm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    command;
    logic signed [SET_W-1:0] speed_value;

    modport source (output valid, command, speed_value, input ready);
    modport sink   (input valid, command, speed_value, output ready);
endinterface

interface dpm_out_if import dpm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [CMP_W-1:0]        right_compare;
    logic [CMP_W-1:0]        left_compare;
    logic                    right_direction_pin;
    logic                    left_direction_pin;
    logic signed [SET_W-1:0] traversal_now;
    logic signed [SET_W-1:0] turn_now;

    modport source (output valid, right_compare, left_compare, right_direction_pin,
                    left_direction_pin, traversal_now, turn_now, input ready);
    modport sink   (input valid, right_compare, left_compare, right_direction_pin,
                    left_direction_pin, traversal_now, turn_now, output ready);
endinterface

// ===== rtl/core/differential_drive_pwm_mixer.sv =====
// Top level: arcade mixing of traversal and turn into two PWM compare values.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      command, speed_value
//  out_ch    out  valid/ready      right/left_compare, right/left_direction_pin,
//                                  traversal_now, turn_now
//  apb       in   psel/penable     gains at 0x0 (traversal) and 0x4 (turn)
//
// Between one accept and the next, a command runs nine sequencer steps,
// six of them on the single shared 24x24 multiplier (gain scaling,
// setting products, reciprocal divides), then mix, overshoot shift and output.
// The result sits in an output register, so the sequencer only waits in its
// last step if the previous result beat has not been taken.
// rst_n is asynchronous; it clears the settings and control state and loads
// the gain defaults.
module differential_drive_pwm_mixer import dpm_pkg::*;
#(
    parameter int MAX_TRAVERSAL_SETTING  = MAX_TRAVERSAL_SETTING_DEF,
    parameter int MAX_TURN_SETTING_LEVEL = MAX_TURN_SETTING_LEVEL_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    dpm_in_if.sink             in_ch,
    dpm_out_if.source          out_ch
);

    // Division by a max setting is a multiply by a rounded-up reciprocal.
    // With the shift at numerator width plus ceil(log2 D) the quotient is
    // exact for every numerator below 2^NUM_W.
    localparam int SHIFT_T = NUM_W + $clog2(MAX_TRAVERSAL_SETTING);
    localparam int SHIFT_U = NUM_W + $clog2(MAX_TURN_SETTING_LEVEL);
    localparam logic [MUL_W-1:0] RECIP_T = MUL_W'(((64'd1 << SHIFT_T)
        + 64'(MAX_TRAVERSAL_SETTING) - 64'd1) / 64'(MAX_TRAVERSAL_SETTING));
    localparam logic [MUL_W-1:0] RECIP_U = MUL_W'(((64'd1 << SHIFT_U)
        + 64'(MAX_TURN_SETTING_LEVEL) - 64'd1) / 64'(MAX_TURN_SETTING_LEVEL));
    localparam logic [MAG_W-1:0] LIM_T = MAG_W'(MAX_TRAVERSAL_SETTING);
    localparam logic [MAG_W-1:0] LIM_U = MAG_W'(MAX_TURN_SETTING_LEVEL);

    localparam logic signed [DRV_W-1:0] DRV_MAX = $signed(DRV_W'(Q_DRIVE_FULL));

    ctl_t              ctl;
    logic              out_busy;
    logic [GAIN_W-1:0] trav_gain;
    logic [GAIN_W-1:0] turn_gain;
    logic [MUL_W-1:0]  mul_a;
    logic [MUL_W-1:0]  mul_b;
    logic [PROD_W-1:0] prod;

    // stored settings
    logic signed [SET_W-1:0] trav_set_reg;
    logic signed [SET_W-1:0] turn_set_reg;

    // intermediate datapath registers
    logic [15:0]             trav_mag_reg;
    logic [15:0]             tmin_reg;
    logic                    dneg_reg;
    logic signed [DRV_W-1:0] left_reg;
    logic signed [DRV_W-1:0] right_reg;
    logic signed [DRV_W-1:0] left_next;
    logic signed [DRV_W-1:0] right_next;

    // output register
    logic                    out_valid_reg;
    logic [CMP_W-1:0]        rcmp_reg;
    logic [CMP_W-1:0]        lcmp_reg;
    logic                    rdir_reg;
    logic                    ldir_reg;
    logic signed [SET_W-1:0] trav_now_reg;
    logic signed [SET_W-1:0] turn_now_reg;

    // combinational helpers
    logic                    moving;
    logic [MAG_W-1:0]        trav_mag_set;
    logic [MAG_W-1:0]        turn_mag_set;
    logic [15:0]             tmax;
    logic [15:0]             tmin_sel;
    logic signed [17:0]      delta;
    logic signed [17:0]      delta_neg;
    logic [15:0]             dmag;
    logic [15:0]             turn_q;
    logic signed [DRV_W-1:0] m_turn;
    logic signed [DRV_W-1:0] turn_v;
    logic signed [DRV_W-1:0] trav_v;
    logic signed [DRV_W-1:0] dl;
    logic signed [DRV_W-1:0] dr;
    logic signed [DRV_W-1:0] diff;
    logic signed [DRV_W-1:0] left_sh;
    logic signed [DRV_W-1:0] right_sh;
    logic [CMP_W-1:0]        rcmp;
    logic [CMP_W-1:0]        lcmp;

    function automatic logic signed [DRV_W-1:0] abs_drv(input logic signed [DRV_W-1:0] v);
        return v[DRV_W-1] ? -v : v;
    endfunction

    function automatic logic signed [DRV_W-1:0] clamp_drv(input logic signed [DRV_W-1:0] v);
        if (v > DRV_MAX)
        begin
            return DRV_MAX;
        end
        else if (v < -DRV_MAX)
        begin
            return -DRV_MAX;
        end
        return v;
    endfunction

    // 255 * (1 - |x|) in Q0.16, truncated; |x| is at most 0.95 here
    function automatic logic [CMP_W-1:0] cmp_of(input logic signed [DRV_W-1:0] v);
        logic [16:0] y;
        logic [24:0] p;
        logic signed [DRV_W-1:0] m;
        m = abs_drv(v);
        y = 17'd65536 - m[16:0];
        p = {y, 8'd0} - 25'(y);
        return p[23:16];
    endfunction

    dpm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .trav_gain (trav_gain),
        .turn_gain (turn_gain)
    );

    assign out_busy = out_valid_reg & ~out_ch.ready;

    dpm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .out_busy (out_busy),
        .ctl      (ctl)
    );

    assign in_ch.ready = ctl.in_ready;

    dpm_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    assign moving       = (trav_mag_reg != 16'd0);
    assign trav_mag_set = mag_set(trav_set_reg);
    assign turn_mag_set = mag_set(turn_set_reg);

    // turn span: tmax - tmin, kept as magnitude and sign for the divide
    assign tmax      = prod[31:16];
    assign tmin_sel  = moving ? Q_TURN_FLOOR_RUN : Q_TURN_FLOOR;
    assign delta     = $signed({2'b00, tmax}) - $signed({2'b00, tmin_sel});
    assign delta_neg = -delta;
    assign dmag      = delta[17] ? delta_neg[15:0] : delta[15:0];

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (ctl.step)
            ST_TSCALE:
            begin
                mul_a = MUL_W'(trav_gain);
                mul_b = MUL_W'(Q_DRIVE_FULL);
            end
            ST_TRAV_X:
            begin
                mul_a = MUL_W'(trav_mag_set);
                mul_b = MUL_W'(prod[31:16]);
            end
            ST_TRAV_Q:
            begin
                mul_a = MUL_W'(prod[NUM_W-1:0]);
                mul_b = RECIP_T;
            end
            ST_TMAX:
            begin
                mul_a = MUL_W'(turn_gain);
                mul_b = MUL_W'(Q_DRIVE_FULL);
            end
            ST_TURN_X:
            begin
                // zero turn wraps here; its contribution is forced to zero later
                mul_a = MUL_W'(turn_mag_set - MAG_W'(1));
                mul_b = MUL_W'(dmag);
            end
            ST_TURN_Q:
            begin
                mul_a = MUL_W'(prod[NUM_W-1:0]);
                mul_b = RECIP_U;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // mix step
    assign turn_q = prod[SHIFT_U +: 16];
    assign m_turn = dneg_reg ? ($signed(DRV_W'(tmin_reg)) - $signed(DRV_W'(turn_q)))
                             : ($signed(DRV_W'(tmin_reg)) + $signed(DRV_W'(turn_q)));
    assign turn_v = (turn_set_reg == '0) ? '0
                  : (turn_set_reg[SET_W-1] ? -m_turn : m_turn);
    assign trav_v = trav_set_reg[SET_W-1] ? -$signed(DRV_W'(trav_mag_reg))
                                          : $signed(DRV_W'(trav_mag_reg));
    assign left_next  = trav_v + turn_v;
    assign right_next = trav_v - turn_v;

    // overshoot past full scale is moved off both sides while moving; its sign is flipped for reverse traversal
    always_comb
    begin
        dl   = left_reg[DRV_W-1] ? (left_reg + DRV_MAX) : (left_reg - DRV_MAX);
        dr   = right_reg[DRV_W-1] ? (right_reg + DRV_MAX) : (right_reg - DRV_MAX);
        diff = '0;
        if (abs_drv(left_reg) > DRV_MAX)
        begin
            diff = diff + dl;
        end
        if (abs_drv(right_reg) > DRV_MAX)
        begin
            diff = diff + dr;
        end
        if (trav_set_reg[SET_W-1])
        begin
            diff = -diff;
        end
        left_sh  = moving ? (left_reg - diff) : left_reg;
        right_sh = moving ? (right_reg - diff) : right_reg;
    end

    assign rcmp = cmp_of(right_reg);
    assign lcmp = cmp_of(left_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trav_set_reg <= '0;
            turn_set_reg <= '0;
        end
        else if (ctl.load_in)
        begin
            if (in_ch.command == CMD_TRAVERSAL)
            begin
                trav_set_reg <= sat_set(in_ch.speed_value, LIM_T);
            end
            else
            begin
                turn_set_reg <= sat_set(in_ch.speed_value, LIM_U);
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        unique case (ctl.step)
            ST_TMAX:
            begin
                trav_mag_reg <= prod[SHIFT_T +: 16];
            end
            ST_TURN_X:
            begin
                tmin_reg <= tmin_sel;
                dneg_reg <= delta[17];
            end
            ST_MIX:
            begin
                left_reg  <= left_next;
                right_reg <= right_next;
            end
            ST_SHIFT:
            begin
                left_reg  <= clamp_drv(left_sh);
                right_reg <= clamp_drv(right_sh);
            end
            default:
            begin
                left_reg <= left_reg;
            end
        endcase
        if (ctl.load_out)
        begin
            rcmp_reg     <= rcmp;
            lcmp_reg     <= lcmp;
            rdir_reg     <= right_reg[DRV_W-1];
            ldir_reg     <= ~left_reg[DRV_W-1];
            trav_now_reg <= trav_set_reg;
            turn_now_reg <= turn_set_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.right_compare       = rcmp_reg;
    assign out_ch.left_compare        = lcmp_reg;
    assign out_ch.right_direction_pin = rdir_reg;
    assign out_ch.left_direction_pin  = ldir_reg;
    assign out_ch.traversal_now       = trav_now_reg;
    assign out_ch.turn_now            = turn_now_reg;

`ifndef SYNTHESIS
    a_trav_range: assert property (@(posedge clk) disable iff (!rst_n)
        (trav_set_reg <= $signed({1'b0, LIM_T})) && (trav_set_reg >= -$signed({1'b0, LIM_T})))
        else $error("traversal setting outside saturation range");

    a_turn_range: assert property (@(posedge clk) disable iff (!rst_n)
        (turn_set_reg <= $signed({1'b0, LIM_U})) && (turn_set_reg >= -$signed({1'b0, LIM_U})))
        else $error("turn setting outside saturation range");

    a_drive_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step == ST_OUT) |-> (abs_drv(left_reg) <= DRV_MAX && abs_drv(right_reg) <= DRV_MAX))
        else $error("drive beyond full scale at output step");

    a_load_needs_free: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.load_out |-> (!out_valid_reg || out_ch.ready))
        else $error("result overwritten before it was taken");
`endif

endmodule

// ===== rtl/core/dpm_mul.sv =====
// Shared unsigned multiplier with registered product.
module dpm_mul import dpm_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;
    logic [PROD_W-1:0] prod_next;

    assign prod_next = PROD_W'(a) * PROD_W'(b);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/core/dpm_cfg.sv =====
// APB gain registers.
module dpm_cfg import dpm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [GAIN_W-1:0]  trav_gain,
    output logic [GAIN_W-1:0]  turn_gain
);

    logic [GAIN_W-1:0] trav_gain_reg;
    logic [GAIN_W-1:0] turn_gain_reg;
    logic              wr_en;
    logic              reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];   // word index, byte lanes ignored

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trav_gain_reg <= TRAV_GAIN_RST;
            turn_gain_reg <= TURN_GAIN_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_TRAV_GAIN: trav_gain_reg <= pwdata[GAIN_W-1:0];
                REG_TURN_GAIN: turn_gain_reg <= pwdata[GAIN_W-1:0];
                default:       trav_gain_reg <= trav_gain_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TRAV_GAIN: prdata = PDATA_W'(trav_gain_reg);
            REG_TURN_GAIN: prdata = PDATA_W'(turn_gain_reg);
            default:       prdata = '0;
        endcase
    end

    assign trav_gain = trav_gain_reg;
    assign turn_gain = turn_gain_reg;

endmodule

// ===== rtl/core/dpm_ctrl.sv =====
// Step sequencer for the shared multiplier datapath.
module dpm_ctrl import dpm_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    input  logic out_busy,
    output ctl_t ctl
);

    step_t state_reg;
    step_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        ctl.step     = state_reg;
        ctl.in_ready = 1'b0;
        ctl.load_in  = 1'b0;
        ctl.load_out = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = ST_TSCALE;
                end
            end
            ST_TSCALE: state_next = ST_TRAV_X;
            ST_TRAV_X: state_next = ST_TRAV_Q;
            ST_TRAV_Q: state_next = ST_TMAX;
            ST_TMAX:   state_next = ST_TURN_X;
            ST_TURN_X: state_next = ST_TURN_Q;
            ST_TURN_Q: state_next = ST_MIX;
            ST_MIX:    state_next = ST_SHIFT;
            ST_SHIFT:  state_next = ST_OUT;
            ST_OUT:
            begin
                // hold until the result register is free
                if (!out_busy)
                begin
                    ctl.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid) |=> (state_reg == ST_TSCALE))
        else $error("accepted beat did not start the sequence");

    a_out_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && out_busy) |=> (state_reg == ST_OUT))
        else $error("left result step while result register busy");

    a_out_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT && !out_busy) |=> (state_reg == ST_IDLE))
        else $error("result step did not return to idle");
`endif

endmodule
